### hw/rtl/gtot_pkg.sv
package gtot_pkg;

  localparam int unsigned MaxTracked = 64;
  localparam int unsigned MapW       = 64;
  localparam int unsigned IdxW       = $clog2(MapW);
  localparam int unsigned SeqW       = 7;
  localparam int unsigned CtrW       = 7;
  localparam int unsigned GenW       = 64;
  localparam int unsigned StepW      = 32;
  localparam int unsigned TseqW      = 8;
  localparam int unsigned StaleW     = 32;
  localparam int unsigned OpW        = 3;
  localparam int unsigned InDataW    = 176;
  localparam int unsigned OutDataW   = 168;

  typedef enum logic [OpW-1:0] {
    OP_RESET    = 3'd0,
    OP_BEGIN    = 3'd1,
    OP_CANCEL   = 3'd2,
    OP_CLOSE    = 3'd3,
    OP_RESERVE  = 3'd4,
    OP_COMPLETE = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_OK               = 4'd0,
    ST_BAD_ID           = 4'd1,
    ST_STALE            = 4'd2,
    ST_CANCELLED        = 4'd3,
    ST_BAD_STATE        = 4'd4,
    ST_EXHAUSTED        = 4'd5,
    ST_EXISTS           = 4'd6,
    ST_STALE_COMPLETION = 4'd7,
    ST_UNKNOWN          = 4'd8,
    ST_DUPLICATE        = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    DP_INVALID   = 3'd0,
    DP_STALE     = 3'd1,
    DP_CANCELLED = 3'd2,
    DP_UNKNOWN   = 3'd3,
    DP_DUPLICATE = 3'd4,
    DP_ACCEPTED  = 3'd5
  } disp_e;

  typedef enum logic [3:0] {
    LIFE_INACTIVE   = 4'b0001,
    LIFE_ACTIVE     = 4'b0010,
    LIFE_CANCELLING = 4'b0100,
    LIFE_CLOSED     = 4'b1000
  } life_e;

  localparam logic [1:0] LcInactive   = 2'd0;
  localparam logic [1:0] LcActive     = 2'd1;
  localparam logic [1:0] LcCancelling = 2'd2;
  localparam logic [1:0] LcClosed     = 2'd3;

  typedef struct packed {
    op_e              op;
    logic [GenW-1:0]  generation;
    logic [StepW-1:0] step_index;
    logic             reserve_kind;
    logic [GenW-1:0]  token_generation;
    logic [TseqW-1:0] token_sequence;
  } item_t;

  typedef struct packed {
    status_e           status;
    disp_e             disposition;
    logic [SeqW-1:0]   granted_sequence;
    logic              granted_kind;
    logic [StepW-1:0]  granted_step;
    logic [1:0]        lifecycle;
    logic              cancel_flag;
    logic [GenW-1:0]   current_generation;
    logic [SeqW-1:0]   next_sequence;
    logic [CtrW-1:0]   accepted_count;
    logic [CtrW-1:0]   completed_count;
    logic [StaleW-1:0] stale_count;
  } result_t;

endpackage

### hw/rtl/generation_tagged_op_tracker_unit.sv
// A result enters the result register when its event advances from the input register.
// Throughput: one transaction per cycle while the output is not stalled; each event is
// evaluated combinationally between the input register and the result register.
// Reset: rst_ni clears the lifecycle to inactive, the generation, flags, counters
// and bitmap, and empties both pipeline registers.
module generation_tagged_op_tracker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // generation[63:0], step_index[95:64], reserve_kind[96],
  // token_generation[160:97], token_sequence[168:161], zero pad.
  input  logic [gtot_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op[2:0].
  input  logic [gtot_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status[3:0], disposition[6:4], granted_sequence[13:7], granted_kind[14],
  // granted_step[46:15], lifecycle[48:47], cancel_flag[49],
  // current_generation[113:50], next_sequence[120:114], accepted_count[127:121],
  // completed_count[134:128], stale_count[166:135], zero pad.
  output logic [gtot_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import gtot_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance;
  logic    in_fire;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op               <= op_e'(s_axis_tuser_i);
      item_q.generation       <= s_axis_tdata_i[63:0];
      item_q.step_index       <= s_axis_tdata_i[95:64];
      item_q.reserve_kind     <= s_axis_tdata_i[96];
      item_q.token_generation <= s_axis_tdata_i[160:97];
      item_q.token_sequence   <= s_axis_tdata_i[168:161];
    end
  end

  gtot_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0,
                            res_q.stale_count,
                            res_q.completed_count,
                            res_q.accepted_count,
                            res_q.next_sequence,
                            res_q.current_generation,
                            res_q.cancel_flag,
                            res_q.lifecycle,
                            res_q.granted_step,
                            res_q.granted_kind,
                            res_q.granted_sequence,
                            res_q.disposition,
                            res_q.status};

`ifndef NO_ASSERTIONS
  a_accept_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.disposition == DP_ACCEPTED) |-> (res_q.status == ST_OK))
    else $error("accepted completion without ok status");

  a_grant_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.granted_sequence != '0) |-> (res_q.status == ST_OK))
    else $error("grant reported with a failing status");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated event did not reach the result register");
`endif

endmodule

### hw/rtl/gtot_core.sv
module gtot_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  gtot_pkg::item_t   item_i,
  output gtot_pkg::result_t res_o
);
  import gtot_pkg::*;

  life_e             life_q, life_d;
  logic [GenW-1:0]   held_q, held_d;
  logic              cancel_q, cancel_d;
  logic [SeqW-1:0]   next_seq_q, next_seq_d;
  logic [MapW-1:0]   map_q, map_d;
  logic [CtrW-1:0]   acc_q, acc_d;
  logic [CtrW-1:0]   comp_q, comp_d;
  logic [StaleW-1:0] stale_q, stale_d;

  logic             gen_zero, tgen_zero, gen_match, tgen_match, live, blocked;
  logic [TseqW-1:0] tseq_m1;
  logic [IdxW-1:0]  bit_idx;

  function automatic logic [1:0] life_code(life_e l);
    logic [1:0] c;
    case (l)
      LIFE_ACTIVE:     c = LcActive;
      LIFE_CANCELLING: c = LcCancelling;
      LIFE_CLOSED:     c = LcClosed;
      default:         c = LcInactive;
    endcase
    return c;
  endfunction

  assign gen_zero   = (item_i.generation == '0);
  assign tgen_zero  = (item_i.token_generation == '0);
  assign gen_match  = (item_i.generation == held_q);
  assign tgen_match = (item_i.token_generation == held_q);
  assign live       = (life_q == LIFE_ACTIVE) || (life_q == LIFE_CANCELLING);
  assign blocked    = (life_q == LIFE_CANCELLING) || cancel_q;
  assign tseq_m1    = item_i.token_sequence - TseqW'(1);
  assign bit_idx    = tseq_m1[IdxW-1:0];

  always_comb begin
    life_d     = life_q;
    held_d     = held_q;
    cancel_d   = cancel_q;
    next_seq_d = next_seq_q;
    map_d      = map_q;
    acc_d      = acc_q;
    comp_d     = comp_q;
    stale_d    = stale_q;
    res_o      = '0;
    res_o.status      = ST_OK;
    res_o.disposition = DP_INVALID;

    case (item_i.op)
      OP_RESET: begin
        life_d     = LIFE_INACTIVE;
        held_d     = '0;
        cancel_d   = 1'b0;
        next_seq_d = SeqW'(1);
        map_d      = '0;
        acc_d      = '0;
        comp_d     = '0;
        stale_d    = '0;
      end
      OP_BEGIN: begin
        if (gen_zero) begin
          res_o.status = ST_BAD_ID;
        end else if (live) begin
          res_o.status = ST_EXISTS;
        end else begin
          life_d     = LIFE_ACTIVE;
          held_d     = item_i.generation;
          cancel_d   = 1'b0;
          next_seq_d = SeqW'(1);
          map_d      = '0;
          acc_d      = '0;
          comp_d     = '0;
          stale_d    = '0;
        end
      end
      OP_CANCEL, OP_CLOSE: begin
        if (gen_zero) begin
          res_o.status = ST_BAD_ID;
        end else if (!gen_match) begin
          res_o.status = ST_STALE;
          stale_d      = stale_q + StaleW'(1);
        end else if (!live) begin
          res_o.status = ST_BAD_STATE;
        end else begin
          life_d   = (item_i.op == OP_CANCEL) ? LIFE_CANCELLING : LIFE_CLOSED;
          cancel_d = 1'b1;
        end
      end
      OP_RESERVE: begin
        if (gen_zero) begin
          res_o.status = ST_BAD_ID;
        end else if (!gen_match) begin
          res_o.status = ST_STALE;
          stale_d      = stale_q + StaleW'(1);
        end else if (blocked) begin
          res_o.status = ST_CANCELLED;
        end else if (life_q != LIFE_ACTIVE) begin
          res_o.status = ST_BAD_STATE;
        end else if (next_seq_q == '0 || next_seq_q > SeqW'(MaxTracked)) begin
          res_o.status = ST_EXHAUSTED;
        end else begin
          res_o.granted_sequence = next_seq_q;
          res_o.granted_kind     = item_i.reserve_kind;
          res_o.granted_step     = item_i.step_index;
          next_seq_d = next_seq_q + SeqW'(1);
          acc_d      = acc_q + CtrW'(1);
        end
      end
      OP_COMPLETE: begin
        if (gen_zero || tgen_zero) begin
          res_o.status = ST_BAD_ID;
        end else if (!gen_match || !tgen_match) begin
          res_o.status      = ST_STALE_COMPLETION;
          res_o.disposition = DP_STALE;
          stale_d           = stale_q + StaleW'(1);
        end else if (blocked) begin
          res_o.status      = ST_CANCELLED;
          res_o.disposition = DP_CANCELLED;
        end else if (life_q != LIFE_ACTIVE) begin
          res_o.status = ST_BAD_STATE;
        end else if (item_i.token_sequence == '0
                     || item_i.token_sequence >= {1'b0, next_seq_q}
                     || item_i.token_sequence > TseqW'(MaxTracked)) begin
          res_o.status      = ST_UNKNOWN;
          res_o.disposition = DP_UNKNOWN;
        end else if (map_q[bit_idx]) begin
          res_o.status      = ST_DUPLICATE;
          res_o.disposition = DP_DUPLICATE;
        end else begin
          map_d[bit_idx]    = 1'b1;
          comp_d            = comp_q + CtrW'(1);
          res_o.disposition = DP_ACCEPTED;
        end
      end
      default: begin
        res_o.status = ST_BAD_STATE;
      end
    endcase

    res_o.lifecycle          = life_code(life_d);
    res_o.cancel_flag        = cancel_d;
    res_o.current_generation = held_d;
    res_o.next_sequence      = next_seq_d;
    res_o.accepted_count     = acc_d;
    res_o.completed_count    = comp_d;
    res_o.stale_count        = stale_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q     <= LIFE_INACTIVE;
      held_q     <= '0;
      cancel_q   <= 1'b0;
      next_seq_q <= SeqW'(1);
      map_q      <= '0;
      acc_q      <= '0;
      comp_q     <= '0;
      stale_q    <= '0;
    end else if (en_i) begin
      life_q     <= life_d;
      held_q     <= held_d;
      cancel_q   <= cancel_d;
      next_seq_q <= next_seq_d;
      map_q      <= map_d;
      acc_q      <= acc_d;
      comp_q     <= comp_d;
      stale_q    <= stale_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_inactive_no_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (life_q == LIFE_INACTIVE) |-> (held_q == '0))
    else $error("inactive tracker holds a generation");

  a_seq_tracks_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_seq_q == acc_q + CtrW'(1))
    else $error("next sequence out of step with accepted count");

  a_comp_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q <= acc_q)
    else $error("more completions than reservations");

  a_map_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(map_q) == int'(comp_q))
    else $error("completion bitmap disagrees with completed count");
`endif

endmodule
